[hw/rtl/swr_pkg.sv]
// ----------------------------------------------------------------------------
// swr_pkg
// Shared types and constants for the sliding window range filter.
// ----------------------------------------------------------------------------
package swr_pkg;

   localparam int CFG_W = 9;

   typedef struct packed {
      logic shift;
      logic push;
      logic clear;
   } cell_ctrl_type;

endpackage

[hw/rtl/swr_cell.sv]
// ----------------------------------------------------------------------------
// swr_cell
// One entry of a monotonic queue: takes its right neighbor's entry on a shift,
// drops itself when dominated and takes the new sample at the queue tail.
// ----------------------------------------------------------------------------
module swr_cell #(
   parameter int SW     = 16,
   parameter int PW     = 9,
   parameter bit IS_MAX = 1'b1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  swr_pkg::cell_ctrl_type   ctrl,
   input  logic signed [SW-1:0]     sample,
   input  logic [PW-1:0]            sample_pos,
   input  logic                     right_valid,
   input  logic signed [SW-1:0]     right_value,
   input  logic [PW-1:0]            right_pos,
   input  logic                     left_keep,
   output logic                     ent_valid,
   output logic signed [SW-1:0]     ent_value,
   output logic [PW-1:0]            ent_pos,
   output logic signed [SW-1:0]     next_value,
   output logic                     keep
);

   logic                 valid_ff, valid_in;
   logic signed [SW-1:0] value_ff, value_in;
   logic [PW-1:0]        pos_ff, pos_in;
   logic                 view_valid;
   logic signed [SW-1:0] view_value;
   logic [PW-1:0]        view_pos;
   logic                 dominated;
   logic                 take;

   always_comb begin
      view_valid = ctrl.shift ? right_valid : valid_ff;
      view_value = ctrl.shift ? right_value : value_ff;
      view_pos   = ctrl.shift ? right_pos   : pos_ff;
      if (ctrl.clear) begin
         view_valid = 1'b0;
      end
      dominated = IS_MAX ? (view_value <= sample) : (view_value >= sample);
      keep      = view_valid && !dominated;
      take      = !keep && left_keep;
   end

   always_comb begin
      valid_in = view_valid;
      value_in = view_value;
      pos_in   = view_pos;
      if (ctrl.push) begin
         if (keep) begin
            valid_in = 1'b1;
         end else if (take) begin
            valid_in = 1'b1;
            value_in = sample;
            pos_in   = sample_pos;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      pos_ff   <= pos_in;
   end

   assign ent_valid  = valid_ff;
   assign ent_value  = value_ff;
   assign ent_pos    = pos_ff;
   assign next_value = value_in;

endmodule

[hw/rtl/swr_chain.sv]
// ----------------------------------------------------------------------------
// swr_chain
// Row of queue cells holding one monotonic queue, front at cell zero.
// ----------------------------------------------------------------------------
module swr_chain #(
   parameter int N      = 256,
   parameter int SW     = 16,
   parameter int PW     = 9,
   parameter bit IS_MAX = 1'b1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  swr_pkg::cell_ctrl_type   ctrl,
   input  logic signed [SW-1:0]     sample,
   input  logic [PW-1:0]            sample_pos,
   output logic                     head0_valid,
   output logic [PW-1:0]            head0_pos,
   output logic                     head1_valid,
   output logic [PW-1:0]            head1_pos,
   output logic signed [SW-1:0]     front_value
);

   logic                 valid_w [N];
   logic signed [SW-1:0] value_w [N];
   logic [PW-1:0]        pos_w   [N];
   logic signed [SW-1:0] next_w  [N];
   logic                 keep_w  [N];

   for (genvar i = 0; i < N; i++) begin : g_cell
      logic                 rv;
      logic signed [SW-1:0] rval;
      logic [PW-1:0]        rpos;
      logic                 lk;

      if (i == N - 1) begin : g_last
         assign rv   = 1'b0;
         assign rval = '0;
         assign rpos = '0;
      end else begin : g_mid
         assign rv   = valid_w[i+1];
         assign rval = value_w[i+1];
         assign rpos = pos_w[i+1];
      end

      if (i == 0) begin : g_first
         assign lk = 1'b1;
      end else begin : g_rest
         assign lk = keep_w[i-1];
      end

      swr_cell #(
         .SW     (SW),
         .PW     (PW),
         .IS_MAX (IS_MAX)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .sample      (sample),
         .sample_pos  (sample_pos),
         .right_valid (rv),
         .right_value (rval),
         .right_pos   (rpos),
         .left_keep   (lk),
         .ent_valid   (valid_w[i]),
         .ent_value   (value_w[i]),
         .ent_pos     (pos_w[i]),
         .next_value  (next_w[i]),
         .keep        (keep_w[i])
      );
   end

   assign head0_valid = valid_w[0];
   assign head0_pos   = pos_w[0];
   assign head1_valid = valid_w[1];
   assign head1_pos   = pos_w[1];
   assign front_value = next_w[0];

endmodule

[hw/rtl/sliding_window_range.sv]
// an accepted sample is registered, then pushed into both queues; results load
//   at the push. throughput: one transaction per cycle while the output is free;
//   once window_len drops, each extra expired front shifts out ahead of the push
// reset: queues empty, window_len = 1, position and fill count zero
// ----------------------------------------------------------------------------
// sliding_window_range
// Streaming sliding-window maximum, minimum and range over two cell-chain
// monotonic queues.
// ----------------------------------------------------------------------------
module sliding_window_range #(
   parameter int MAX_WINDOW   = 256,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [swr_pkg::CFG_W-1:0]       csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]  req_sample,
   input  logic                            req_start_of_sequence,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]  rsp_window_max,
   output logic signed [SAMPLE_WIDTH-1:0]  rsp_window_min,
   output logic [SAMPLE_WIDTH-1:0]         rsp_window_range,
   output logic                            rsp_window_full
);

   localparam int SW    = SAMPLE_WIDTH;
   localparam int PW    = $clog2(2 * MAX_WINDOW);
   localparam int LEN_W = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W = (LEN_W > swr_pkg::CFG_W) ? LEN_W : swr_pkg::CFG_W;
   localparam logic [PW:0]      MODULUS  = (PW + 1)'(2 * MAX_WINDOW);
   localparam logic [PW-1:0]    POS_LAST = PW'(2 * MAX_WINDOW - 1);
   localparam logic [CMP_W-1:0] MAX_CMP  = CMP_W'(MAX_WINDOW);
   localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_WINDOW);

   function automatic logic [PW-1:0] age_of(input logic [PW-1:0] now_pos,
                                            input logic [PW-1:0] ent_pos);
      logic [PW:0] wide;
      wide = {1'b0, now_pos} - {1'b0, ent_pos};
      if (now_pos < ent_pos) begin
         wide = wide + MODULUS;
      end
      return wide[PW-1:0];
   endfunction

   logic [swr_pkg::CFG_W-1:0] window_len_ff;
   logic                      busy_ff, busy_in;
   logic signed [SW-1:0]      sample_ff;
   logic                      sos_ff;
   logic [PW-1:0]             pos_ff, pos_in;
   logic [LEN_W-1:0]          fill_ff, fill_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]      max_ff, min_ff;
   logic [SW-1:0]             range_ff;
   logic                      full_ff;

   logic [CMP_W-1:0]          wl_ext;
   logic [LEN_W-1:0]          len_eff;
   logic [PW-1:0]             len_pos;
   logic [PW-1:0]             pos_eff;
   logic [LEN_W-1:0]          fill_eff;
   logic                      out_free;
   logic                      accept;
   logic                      push;
   logic                      more;
   logic                      mx_exp0, mx_exp1, mn_exp0, mn_exp1;
   logic                      mx_h0v, mx_h1v, mn_h0v, mn_h1v;
   logic [PW-1:0]             mx_h0p, mx_h1p, mn_h0p, mn_h1p;
   logic signed [SW-1:0]      mx_front, mn_front;
   swr_pkg::cell_ctrl_type    mx_ctrl, mn_ctrl;

   // effective window length
   always_comb begin
      wl_ext = CMP_W'(window_len_ff);
      if (wl_ext == '0) begin
         len_eff = LEN_W'(1);
      end else if (wl_ext > MAX_CMP) begin
         len_eff = MAX_LEN;
      end else begin
         len_eff = LEN_W'(wl_ext);
      end
      len_pos = PW'(len_eff);
   end

   // front expiry and transaction control
   always_comb begin
      pos_eff  = sos_ff ? '0 : pos_ff;
      fill_eff = sos_ff ? '0 : fill_ff;
      mx_exp0  = !sos_ff && mx_h0v && (age_of(pos_eff, mx_h0p) >= len_pos);
      mx_exp1  = !sos_ff && mx_h1v && (age_of(pos_eff, mx_h1p) >= len_pos);
      mn_exp0  = !sos_ff && mn_h0v && (age_of(pos_eff, mn_h0p) >= len_pos);
      mn_exp1  = !sos_ff && mn_h1v && (age_of(pos_eff, mn_h1p) >= len_pos);
      more     = (mx_exp0 && mx_exp1) || (mn_exp0 && mn_exp1);
      out_free = !rsp_valid_ff || !rsp_stall;
      push     = busy_ff && !more && out_free;

      mx_ctrl.shift = busy_ff && mx_exp0 && (more || out_free);
      mx_ctrl.push  = push;
      mx_ctrl.clear = push && sos_ff;
      mn_ctrl.shift = busy_ff && mn_exp0 && (more || out_free);
      mn_ctrl.push  = push;
      mn_ctrl.clear = push && sos_ff;

      req_stall = busy_ff && !push;
      accept    = req_valid && !req_stall;

      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (push) begin
         busy_in = 1'b0;
      end

      pos_in  = pos_ff;
      fill_in = fill_ff;
      if (push) begin
         pos_in  = (pos_eff == POS_LAST) ? '0 : pos_eff + PW'(1);
         fill_in = (fill_eff < MAX_LEN) ? fill_eff + LEN_W'(1) : fill_eff;
      end

      rsp_valid_in = rsp_valid_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   swr_chain #(
      .N      (MAX_WINDOW),
      .SW     (SW),
      .PW     (PW),
      .IS_MAX (1'b1)
   ) u_max_chain (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (mx_ctrl),
      .sample      (sample_ff),
      .sample_pos  (pos_eff),
      .head0_valid (mx_h0v),
      .head0_pos   (mx_h0p),
      .head1_valid (mx_h1v),
      .head1_pos   (mx_h1p),
      .front_value (mx_front)
   );

   swr_chain #(
      .N      (MAX_WINDOW),
      .SW     (SW),
      .PW     (PW),
      .IS_MAX (1'b0)
   ) u_min_chain (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (mn_ctrl),
      .sample      (sample_ff),
      .sample_pos  (pos_eff),
      .head0_valid (mn_h0v),
      .head0_pos   (mn_h0p),
      .head1_valid (mn_h1v),
      .head1_pos   (mn_h1p),
      .front_value (mn_front)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= swr_pkg::CFG_W'(1);
         busy_ff       <= 1'b0;
         pos_ff        <= '0;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            window_len_ff <= csr_write_data;
         end
         busy_ff      <= busy_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // transaction payload and result registers
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_sample;
         sos_ff    <= req_start_of_sequence;
      end
      if (push) begin
         max_ff   <= mx_front;
         min_ff   <= mn_front;
         range_ff <= SW'(mx_front - mn_front);
         full_ff  <= (fill_in >= len_eff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_max   = max_ff;
   assign rsp_window_min   = min_ff;
   assign rsp_window_range = range_ff;
   assign rsp_window_full  = full_ff;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding window range filter. A scoreboard keeps
// its own pair of monotonic queues and predicts max, min, range and the full
// flag for every accepted transaction. Directed corner cases come first. Then
// come random phases with varied window lengths and sample shapes. Both sides
// idle at random, except in a steady stretch of the random phases.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int SAMPLE_W     = 16;
   localparam int WINDOW_CAP   = 256;
   localparam int POS_W        = 9;
   localparam int RANDOM_ITEMS = 1850;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct {
      sample_type       value;
      logic [POS_W-1:0] pos;
   } queue_entry_type;

   typedef struct {
      sample_type          wmax;
      sample_type          wmin;
      logic [SAMPLE_W-1:0] wrange;
      logic                full;
   } window_result_type;

   typedef enum {PAT_RANDOM, PAT_NARROW, PAT_RAMP, PAT_EXTREME} pattern_type;

   class window_extremes_model;
      logic [swr_pkg::CFG_W-1:0] len_reg;
      queue_entry_type           min_q[$];
      queue_entry_type           max_q[$];
      logic [POS_W-1:0]          position;
      int unsigned               fill;
      window_result_type         expected_windows[$];
      int unsigned               failures;

      function new();
         len_reg  = swr_pkg::CFG_W'(1);
         position = '0;
         fill     = 0;
         failures = 0;
      endfunction

      function int unsigned effective_len();
         if (len_reg == 0) return 1;
         if (len_reg > WINDOW_CAP) return WINDOW_CAP;
         return 32'(len_reg);
      endfunction

      function logic [POS_W-1:0] age_of(logic [POS_W-1:0] pos);
         return position - pos;
      endfunction

      function void note_sample(sample_type s, logic sos);
         int unsigned       len;
         queue_entry_type   e;
         window_result_type r;
         len = effective_len();
         if (sos) begin
            min_q.delete();
            max_q.delete();
            position = '0;
            fill     = 0;
         end
         while (min_q.size() > 0 && age_of(min_q[0].pos) >= len) min_q.delete(0);
         while (max_q.size() > 0 && age_of(max_q[0].pos) >= len) max_q.delete(0);
         while (min_q.size() > 0 && min_q[$].value >= s) min_q.delete(min_q.size() - 1);
         while (max_q.size() > 0 && max_q[$].value <= s) max_q.delete(max_q.size() - 1);
         e.value = s;
         e.pos   = position;
         if (min_q.size() < WINDOW_CAP) min_q.insert(min_q.size(), e);
         if (max_q.size() < WINDOW_CAP) max_q.insert(max_q.size(), e);
         if (fill < WINDOW_CAP) fill++;
         r.wmax   = max_q[0].value;
         r.wmin   = min_q[0].value;
         r.wrange = r.wmax - r.wmin;
         r.full   = (fill >= len);
         expected_windows.insert(expected_windows.size(), r);
         position = position + POS_W'(1);
      endfunction

      function void check_result(window_result_type got);
         window_result_type want;
         if (expected_windows.size() == 0) begin
            $error("unexpected transaction: max %0d min %0d", got.wmax, got.wmin);
            failures++;
            return;
         end
         want = expected_windows[0];
         expected_windows.delete(0);
         if (got.wmax !== want.wmax) begin
            $error("window_max: expected %0d, got %0d", want.wmax, got.wmax);
            failures++;
         end
         if (got.wmin !== want.wmin) begin
            $error("window_min: expected %0d, got %0d", want.wmin, got.wmin);
            failures++;
         end
         if (got.wrange !== want.wrange) begin
            $error("window_range: expected %0d, got %0d", want.wrange, got.wrange);
            failures++;
         end
         if (got.full !== want.full) begin
            $error("window_full: expected %0d, got %0d", want.full, got.full);
            failures++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_write_enable;
   logic [swr_pkg::CFG_W-1:0] csr_write_data;
   logic                      req_valid;
   logic                      req_stall;
   sample_type                req_sample;
   logic                      req_start_of_sequence;
   logic                      rsp_valid;
   logic                      rsp_stall;
   sample_type                rsp_window_max;
   sample_type                rsp_window_min;
   logic [SAMPLE_W-1:0]       rsp_window_range;
   logic                      rsp_window_full;

   window_extremes_model extremes;
   bit                   steady;
   int unsigned          sent;

   sliding_window_range u_top (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_sample            (req_sample),
      .req_start_of_sequence (req_start_of_sequence),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_window_max        (rsp_window_max),
      .rsp_window_min        (rsp_window_min),
      .rsp_window_range      (rsp_window_range),
      .rsp_window_full       (rsp_window_full)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= !steady && ($urandom_range(0, 99) < 22);
      end
   end

   always @(posedge clock) begin : result_monitor
      window_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.wmax   = rsp_window_max;
         got.wmin   = rsp_window_min;
         got.wrange = rsp_window_range;
         got.full   = rsp_window_full;
         extremes.check_result(got);
      end
   end

   task automatic send_sample(sample_type s, logic sos);
      while (!steady && $urandom_range(0, 99) < 22) begin
         @(negedge clock);
         req_valid             <= 1'b0;
         req_sample            <= sample_type'($urandom);
         req_start_of_sequence <= 1'($urandom);
         @(posedge clock);
      end
      @(negedge clock);
      req_valid             <= 1'b1;
      req_sample            <= s;
      req_start_of_sequence <= sos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      extremes.note_sample(s, sos);
      sent++;
   endtask

   task automatic write_window_len(logic [swr_pkg::CFG_W-1:0] v);
      @(negedge clock);
      req_valid <= 1'b0;
      while (extremes.expected_windows.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data   <= swr_pkg::CFG_W'($urandom);
      extremes.len_reg = v;
   endtask

   function automatic logic [swr_pkg::CFG_W-1:0] pick_window_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 6) return swr_pkg::CFG_W'(0);
      if (r < 12) return swr_pkg::CFG_W'(256);
      if (r < 16) return swr_pkg::CFG_W'(511);
      if (r < 20) return swr_pkg::CFG_W'($urandom_range(257, 510));
      if (r < 30) return swr_pkg::CFG_W'($urandom_range(17, 255));
      return swr_pkg::CFG_W'($urandom_range(1, 16));
   endfunction

   initial begin
      int unsigned len_eff;
      int unsigned phase_items;
      int unsigned base;
      int          step;
      pattern_type pattern;
      sample_type  ramp;
      sample_type  s;
      logic        sos;
      extremes              = new();
      steady                = 1'b0;
      sent                  = 0;
      reset                 = 1'b1;
      csr_write_enable      = 1'b0;
      csr_write_data        = '0;
      req_valid             = 1'b0;
      req_sample            = '0;
      req_start_of_sequence = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset length of one, first sample without a start flag
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(16'shFFFF, 1'b0);
      // full-scale range and ties
      write_window_len(swr_pkg::CFG_W'(2));
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh8000, 1'b0);
      // zero length acts as one
      write_window_len(swr_pkg::CFG_W'(0));
      send_sample(16'sd5, 1'b0);
      send_sample(-16'sd5, 1'b0);
      // oversized length saturates
      write_window_len(swr_pkg::CFG_W'(511));
      send_sample(16'sd100, 1'b1);
      send_sample(16'sd200, 1'b0);
      send_sample(16'sd150, 1'b0);
      send_sample(16'sd120, 1'b0);
      // shrink mid-sequence, then grow again
      write_window_len(swr_pkg::CFG_W'(3));
      send_sample(-16'sd7, 1'b0);
      send_sample(16'sd3, 1'b0);
      write_window_len(swr_pkg::CFG_W'(256));
      send_sample(16'sd1, 1'b0);

      base = sent;
      while (sent - base < RANDOM_ITEMS) begin
         write_window_len(pick_window_len());
         len_eff     = extremes.effective_len();
         phase_items = (len_eff > 24) ? len_eff + $urandom_range(10, 60)
                                      : $urandom_range(20, 70);
         pattern     = pattern_type'($urandom_range(0, 3));
         ramp        = sample_type'($urandom);
         step        = $urandom_range(1, 300);
         if ($urandom_range(0, 1)) step = -step;
         for (int i = 0; i < phase_items && sent - base < RANDOM_ITEMS; i++) begin
            case (pattern)
               PAT_RANDOM: s = sample_type'($urandom);
               PAT_NARROW: s = sample_type'(int'($urandom_range(0, 6)) - 3);
               PAT_RAMP: begin
                  ramp = ramp + sample_type'(step);
                  s    = ($urandom_range(0, 9) == 0) ? sample_type'($urandom) : ramp;
               end
               default: begin
                  case ($urandom_range(0, 3))
                     0:       s = 16'sh8000;
                     1:       s = 16'sh7FFF;
                     2:       s = 16'sh0000;
                     default: s = 16'shFFFF;
                  endcase
               end
            endcase
            if (i == 0) sos = 1'($urandom);
            else sos = (len_eff <= 24) && ($urandom_range(0, 99) < 3);
            steady = (sent - base >= 600) && (sent - base < 900);
            send_sample(s, sos);
         end
      end
      steady = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (extremes.expected_windows.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (extremes.failures == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_top failed");
      $finish;
   end

endmodule
